FILE: src/fiv_pkg.sv
// fiv_pkg: shared types, constants and tables for the firmware image verifier
// no dependencies

package fiv_pkg;

	localparam int unsigned MAX_IMAGE_BYTES_DEF = 1040384;
	localparam int unsigned MANIFEST_BYTES_DEF  = 64;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [7:0] BOOT_MAGIC0 = 8'hEA;
	localparam logic [7:0] BOOT_MAGIC1 = 8'h04;
	localparam logic [7:0] MODE_DOUT   = 8'h03;
	localparam logic [7:0] RAM_MAGIC   = 8'hE9;
	localparam logic [7:0] TARGET_ANY  = 8'hFF;
	localparam logic [7:0] MAN_VER     = 8'h01;

	localparam logic [2:0] ADDR_IMAGE_SIZE = 3'd0;
	localparam logic [2:0] ADDR_TARGET_ROM = 3'd4;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_SIZE         = 4'd1,
		ST_MAGIC        = 4'd2,
		ST_MODE         = 4'd3,
		ST_IROM         = 4'd4,
		ST_NO_RAM_HDR   = 4'd5,
		ST_RAM_HDR      = 4'd6,
		ST_NO_MANIFEST  = 4'd7,
		ST_MAN_MAGIC    = 4'd8,
		ST_VERSION      = 4'd9,
		ST_MAN_MODE     = 4'd10,
		ST_SIZE_MISM    = 4'd11,
		ST_TARGET       = 4'd12,
		ST_BOARD        = 4'd13,
		ST_CRC          = 4'd14,
		ST_TRUNCATED    = 4'd15
	} status_t;

	// one classified byte handed from the front to the back part
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        absorb;
		logic        zero_crc;
		logic [19:0] count;
	} item_t;

	// verdict of one image
	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] crc;
		logic [19:0] offset;
		logic [7:0]  target;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] j);
		logic [7:0] r;
		case (j)
			3'd0: r = 8'h49;
			3'd1: r = 8'h52;
			3'd2: r = 8'h41;
			3'd3: r = 8'h43;
			3'd4: r = 8'h4F;
			3'd5: r = 8'h54;
			3'd6: r = 8'h41;
			default: r = 8'h31;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] board_byte(input logic [4:0] j);
		logic [7:0] r;
		case (j)
			5'd0: r = 8'h47;
			5'd1: r = 8'h4B;
			5'd2: r = 8'h30;
			5'd3: r = 8'h31;
			5'd4: r = 8'h5F;
			5'd5: r = 8'h49;
			5'd6: r = 8'h52;
			5'd7: r = 8'h5F;
			5'd8: r = 8'h4D;
			5'd9: r = 8'h49;
			5'd10: r = 8'h4E;
			5'd11: r = 8'h49;
			5'd12: r = 8'h5F;
			5'd13: r = 8'h56;
			5'd14: r = 8'h31;
			5'd15: r = 8'h30;
			5'd16: r = 8'h35;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] v);
		logic [31:0] x;
		x = c ^ {24'd0, v};
		for (int i = 0; i < 8; i++)
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		return x;
	endfunction

endpackage

FILE: src/fiv_front.sv
// fiv_front: counts stream bytes and marks which ones feed the image check
// depends on fiv_pkg

module fiv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        s_data,
	input  logic              s_last,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic [19:0]       image_size,
	output fiv_pkg::item_t    q_item,
	output logic              q_valid,
	input  logic              q_ready
);
	import fiv_pkg::*;

	logic [19:0] pos_q;
	logic [19:0] pos_next;
	logic        take;

	assign s_ready  = q_ready;
	assign q_valid  = s_valid;
	assign take     = s_valid && q_ready;
	assign pos_next = (pos_q == 20'hFFFFF) ? pos_q : pos_q + 20'd1;

	always_comb begin
		q_item          = '0;
		q_item.data     = s_data;
		q_item.last     = s_last;
		q_item.absorb   = pos_q < image_size;
		q_item.zero_crc = 1'b0;
		q_item.count    = pos_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= s_last ? 20'd0 : pos_next;
		end
	end

endmodule

FILE: src/fiv_fifo.sv
// fiv_fifo: two-entry queue between front and back parts
// depends on fiv_pkg

module fiv_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  fiv_pkg::item_t  in_item,
	input  logic            in_valid,
	output logic            in_ready,
	output fiv_pkg::item_t  out_item,
	output logic            out_valid,
	input  logic            out_ready
);
	import fiv_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = mem_q[rp_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("queue overflow");
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad queue count");
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !out_valid) else $error("empty queue shows data");

endmodule

FILE: src/fiv_back.sv
// fiv_back: parses headers and manifest, runs the CRC and forms the verdict
// depends on fiv_pkg

module fiv_back #(
	parameter int unsigned MAX_IMAGE_BYTES = fiv_pkg::MAX_IMAGE_BYTES_DEF,
	parameter int unsigned MANIFEST_BYTES  = fiv_pkg::MANIFEST_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fiv_pkg::item_t    q_item,
	input  logic              q_valid,
	output logic              q_ready,
	input  logic [19:0]       image_size,
	input  logic [7:0]        target_rom,
	output fiv_pkg::result_t  r_data,
	output logic              r_valid,
	input  logic              r_ready
);
	import fiv_pkg::*;

	localparam logic [32:0] MB = 33'(MANIFEST_BYTES);

	logic [19:0] pos_q;
	logic [31:0] crc_q, len_q, addr_q, entry_q, rentry_q, msize_q, mcrc_q;
	logic [7:0]  hb_q [8];
	logic [2:0]  flags_q;
	logic        rv_q;
	result_t     r_q;

	logic        take;
	logic [32:0] r_pos, q_pos, m_pos, k_off, j_off;
	logic        in_ram, in_man, man_ok;
	logic [7:0]  v;
	logic [31:0] crc_n, len_n, entry_n, rentry_n, msize_n, mcrc_n, addr_n;
	logic [7:0]  hb_n [8];
	logic [2:0]  flags_n;
	status_t     st;
	logic [32:0] sz33;

	assign q_ready = !rv_q || r_ready;
	assign take    = q_valid && q_ready;
	assign r_valid = rv_q;
	assign r_data  = r_q;

	always_comb begin
		r_pos  = 33'd16 + {1'b0, len_q};
		q_pos  = {13'd0, pos_q};
		m_pos  = r_pos - MB;
		k_off  = q_pos - r_pos;
		j_off  = q_pos - m_pos;
		in_ram = (pos_q >= 20'd16) && (q_pos >= r_pos) && (q_pos < r_pos + 33'd8);
		man_ok = {1'b0, len_q} >= MB;
		in_man = (pos_q >= 20'd16) && man_ok && (q_pos >= m_pos) && (q_pos < r_pos);
		v = q_item.data;
		len_n = len_q; addr_n = addr_q; entry_n = entry_q; rentry_n = rentry_q;
		msize_n = msize_q; mcrc_n = mcrc_q; flags_n = flags_q;
		for (int i = 0; i < 8; i++) hb_n[i] = hb_q[i];
		if (q_item.absorb) begin
			if (pos_q < 20'd16) begin
				if (pos_q < 20'd3) hb_n[3'(pos_q) + 3'd4] = q_item.data;
				else if (pos_q >= 20'd4 && pos_q < 20'd8)
					entry_n[{pos_q[1:0], 3'b000} +: 8] = q_item.data;
				else if (pos_q >= 20'd8 && pos_q < 20'd12)
					addr_n[{pos_q[1:0], 3'b000} +: 8] = q_item.data;
				else if (pos_q >= 20'd12)
					len_n[{pos_q[1:0], 3'b000} +: 8] = q_item.data;
			end else begin
				if (in_ram) begin
					if (k_off[2:0] == 3'd0) hb_n[7] = q_item.data;
					else if (k_off[2:0] == 3'd2) begin
						if (q_item.data != MODE_DOUT) flags_n[0] = 1'b0;
					end else if (k_off[2])
						rentry_n[{k_off[1:0], 3'b000} +: 8] = q_item.data;
				end
				if (in_man) begin
					if (j_off < 33'd8) begin
						if (q_item.data != magic_byte(j_off[2:0])) flags_n[1] = 1'b0;
					end else if (j_off < 33'd12)
						hb_n[{1'b0, j_off[1:0]}] = q_item.data;
					else if (j_off < 33'd16)
						msize_n[{j_off[1:0], 3'b000} +: 8] = q_item.data;
					else if (j_off < 33'd20) begin
						mcrc_n[{j_off[1:0], 3'b000} +: 8] = q_item.data;
						v = 8'd0;
					end else if (j_off < 33'd40) begin
						if (q_item.data != board_byte(5'(j_off - 33'd20))) flags_n[2] = 1'b0;
					end
				end
			end
			crc_n = crc_byte(crc_q, v);
		end else begin
			crc_n = crc_q;
		end
	end

	always_comb begin
		sz33 = {13'd0, image_size};
		if (image_size < 20'd16 || 32'(image_size) > MAX_IMAGE_BYTES) st = ST_SIZE;
		else if (q_item.count < image_size) st = ST_TRUNCATED;
		else if (hb_n[4] != BOOT_MAGIC0 || hb_n[5] != BOOT_MAGIC1) st = ST_MAGIC;
		else if (hb_n[6] != MODE_DOUT) st = ST_MODE;
		else if (addr_n != 32'd0 || len_n == 32'd0 || {1'b0, len_n} > sz33 - 33'd16)
			st = ST_IROM;
		else if (33'd24 + {1'b0, len_n} > sz33) st = ST_NO_RAM_HDR;
		else if (hb_n[7] != RAM_MAGIC || !flags_n[0] || rentry_n != entry_n) st = ST_RAM_HDR;
		else if ({1'b0, len_n} < MB) st = ST_NO_MANIFEST;
		else if (!flags_n[1]) st = ST_MAN_MAGIC;
		else if (hb_n[0] != MAN_VER || hb_n[1] != MAN_VER) st = ST_VERSION;
		else if (hb_n[3] != MODE_DOUT) st = ST_MAN_MODE;
		else if (msize_n != 32'(image_size)) st = ST_SIZE_MISM;
		else if (hb_n[2] != TARGET_ANY && hb_n[2] != target_rom) st = ST_TARGET;
		else if (!flags_n[2]) st = ST_BOARD;
		else if (~crc_n != mcrc_n) st = ST_CRC;
		else st = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (take && q_item.last) begin
			r_q.status <= st;
			r_q.crc    <= (st == ST_OK || st == ST_CRC) ? ~crc_n : 32'd0;
			if (st == ST_OK || (st >= ST_MAN_MAGIC && st <= ST_CRC)) begin
				r_q.offset <= 20'(33'd16 + {1'b0, len_n} - MB);
				r_q.target <= hb_n[2];
			end else begin
				r_q.offset <= '0;
				r_q.target <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
			pos_q <= '0; crc_q <= CRC_INIT; len_q <= '0; addr_q <= '0;
			entry_q <= '0; rentry_q <= '0; msize_q <= '0; mcrc_q <= '0;
			flags_q <= '1;
			for (int i = 0; i < 8; i++) hb_q[i] <= '0;
		end else begin
			if (r_valid && r_ready) rv_q <= 1'b0;
			if (take) begin
				if (q_item.last) begin
					rv_q <= 1'b1;
					pos_q <= '0; crc_q <= CRC_INIT; len_q <= '0; addr_q <= '0;
					entry_q <= '0; rentry_q <= '0; msize_q <= '0; mcrc_q <= '0;
					flags_q <= '1;
					for (int i = 0; i < 8; i++) hb_q[i] <= '0;
				end else begin
					pos_q <= (pos_q == 20'hFFFFF) ? pos_q : pos_q + 20'd1;
					crc_q <= crc_n; len_q <= len_n; addr_q <= addr_n;
					entry_q <= entry_n; rentry_q <= rentry_n;
					msize_q <= msize_n; mcrc_q <= mcrc_n; flags_q <= flags_n;
					for (int i = 0; i < 8; i++) hb_q[i] <= hb_n[i];
				end
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_data)) else $error("result dropped");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |-> !q_ready) else $error("accepted while result stalled");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && q_item.last |=> pos_q == 20'd0 && crc_q == CRC_INIT) else $error("no clear");

endmodule

FILE: src/firmware_image_verifier_top.sv
// firmware_image_verifier_top: streaming firmware image checker
// byte input on s_axis, one verdict per image on m_axis, apb register port
// channels: s_axis takes one image byte per transfer, tlast on the final byte.
// m_axis gives one verdict transfer per image, after the tlast byte.
// throughput: one byte per cycle while the verdict is not stalled; the crc byte update
// and field compares are done in the back part.
// the tlast byte is stored in the queue, then taken by the back part, which
// registers the verdict; bytes waiting ahead of it in the queue are taken first.
// registers: image_size at 0x0, target_rom at 0x4; write them only while idle, the block does not enforce it.
// reset clears the position and parsed fields and sets the crc to its initial value; registers return to zero.
// a stalled receiver holds the verdict; the two-entry queue fills, then
// s_axis_tready drops until the verdict is taken.

module firmware_image_verifier_top #(
	parameter int unsigned MAX_IMAGE_BYTES = fiv_pkg::MAX_IMAGE_BYTES_DEF,
	parameter int unsigned MANIFEST_BYTES  = fiv_pkg::MANIFEST_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // status, crc_value, manifest_offset, manifest_target
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fiv_pkg::*;

	logic [19:0] image_size_q;
	logic [7:0]  target_rom_q;
	item_t       f_item, b_item;
	logic        f_valid, f_ready, b_valid, b_ready;
	result_t     res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
			target_rom_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_IMAGE_SIZE) image_size_q <= pwdata[19:0];
			else if (paddr == ADDR_TARGET_ROM) target_rom_q <= pwdata[7:0];
		end
	end

	always_comb begin
		if (paddr == ADDR_IMAGE_SIZE) prdata = {12'd0, image_size_q};
		else if (paddr == ADDR_TARGET_ROM) prdata = {24'd0, target_rom_q};
		else prdata = '0;
	end

	fiv_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_data(s_axis_tdata), .s_last(s_axis_tlast),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.image_size(image_size_q),
		.q_item(f_item), .q_valid(f_valid), .q_ready(f_ready)
	);

	fiv_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_item(f_item), .in_valid(f_valid), .in_ready(f_ready),
		.out_item(b_item), .out_valid(b_valid), .out_ready(b_ready)
	);

	fiv_back #(
		.MAX_IMAGE_BYTES(MAX_IMAGE_BYTES),
		.MANIFEST_BYTES(MANIFEST_BYTES)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_item(b_item), .q_valid(b_valid), .q_ready(b_ready),
		.image_size(image_size_q), .target_rom(target_rom_q),
		.r_data(res), .r_valid(m_axis_tvalid), .r_ready(m_axis_tready)
	);

	assign m_axis_tdata = {res.target, res.offset, res.crc, res.status};

endmodule

FILE: sim/fiv_checker.sv
// fiv_checker: watches the byte, verdict and register channels of the image verifier,
// predicts each verdict and compares it field by field. depends on fiv_pkg
`timescale 1ns / 1ps

module fiv_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // last
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,   // status, crc_value, manifest_offset, manifest_target
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          verdicts_seen
);
	import fiv_pkg::*;

	localparam int unsigned MAX_BYTES = 1040384;
	localparam int unsigned MAN_BYTES = 64;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] crc;
		logic [19:0] offset;
		logic [7:0]  target;
	} verdict_t;

	logic [7:0] magic_ref [8] = '{8'h49, 8'h52, 8'h41, 8'h43, 8'h4F, 8'h54, 8'h41, 8'h31};
	logic [7:0] board_ref [20] = '{8'h47, 8'h4B, 8'h30, 8'h31, 8'h5F, 8'h49, 8'h52, 8'h5F,
		8'h4D, 8'h49, 8'h4E, 8'h49, 8'h5F, 8'h56, 8'h31, 8'h30, 8'h35, 8'h00, 8'h00, 8'h00};

	verdict_t verdict_q[$];

	logic [19:0] cfg_size;
	logic [7:0]  cfg_target;
	logic [19:0] pos;
	logic [31:0] crc_acc, irom_len, irom_addr, entry, ram_entry, man_size, man_crc;
	logic [7:0]  hdr [8];
	logic [2:0]  flags;

	assign pending = verdict_q.size();

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] v);
		logic [31:0] x;
		x = c ^ {24'd0, v};
		for (int i = 0; i < 8; i++)
			x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
		return x;
	endfunction

	function automatic logic [31:0] put_le(input logic [31:0] acc, input logic [7:0] b,
			input longint unsigned k);
		return acc | ({24'd0, b} << ((k & 3) * 8));
	endfunction

	task automatic clear_image();
		pos = '0;
		crc_acc = 32'hFFFFFFFF;
		irom_len = '0;
		irom_addr = '0;
		entry = '0;
		ram_entry = '0;
		man_size = '0;
		man_crc = '0;
		for (int i = 0; i < 8; i++) hdr[i] = '0;
		flags = 3'b111;
	endtask

	task automatic parse_byte(input logic [19:0] p, input logic [7:0] b);
		logic [7:0] v;
		longint unsigned len, r, q, k, m, j;
		v = b;
		len = irom_len;
		r = 16 + len;
		q = p;
		if (p < 16) begin
			if (p < 3) hdr[4 + p] = b;
			else if (p >= 4 && p < 8) entry = put_le(entry, b, p - 4);
			else if (p >= 8 && p < 12) irom_addr = put_le(irom_addr, b, p - 8);
			else if (p >= 12) irom_len = put_le(irom_len, b, p - 12);
		end else begin
			if (q >= r && q < r + 8) begin
				k = q - r;
				if (k == 0) hdr[7] = b;
				else if (k == 2 && b != MODE_DOUT) flags[0] = 1'b0;
				else if (k >= 4) ram_entry = put_le(ram_entry, b, k - 4);
			end
			if (len >= MAN_BYTES) begin
				m = r - MAN_BYTES;
				if (q >= m && q < r) begin
					j = q - m;
					if (j < 8) begin
						if (b != magic_ref[j]) flags[1] = 1'b0;
					end else if (j < 12) begin
						hdr[j - 8] = b;
					end else if (j < 16) begin
						man_size = put_le(man_size, b, j - 12);
					end else if (j < 20) begin
						man_crc = put_le(man_crc, b, j - 16);
						v = 8'h00;
					end else if (j < 40) begin
						if (b != board_ref[j - 20]) flags[2] = 1'b0;
					end
				end
			end
		end
		crc_acc = crc_step(crc_acc, v);
	endtask

	function automatic status_t judge_image();
		longint unsigned len, sz;
		len = irom_len;
		sz = cfg_size;
		if (sz < 16 || sz > MAX_BYTES) return ST_SIZE;
		if (pos < cfg_size) return ST_TRUNCATED;
		if (hdr[4] != BOOT_MAGIC0 || hdr[5] != BOOT_MAGIC1) return ST_MAGIC;
		if (hdr[6] != MODE_DOUT) return ST_MODE;
		if (irom_addr != 0 || len == 0 || len > sz - 16) return ST_IROM;
		if (16 + len + 8 > sz) return ST_NO_RAM_HDR;
		if (hdr[7] != RAM_MAGIC || !flags[0] || ram_entry != entry) return ST_RAM_HDR;
		if (len < MAN_BYTES) return ST_NO_MANIFEST;
		if (!flags[1]) return ST_MAN_MAGIC;
		if (hdr[0] != MAN_VER || hdr[1] != MAN_VER) return ST_VERSION;
		if (hdr[3] != MODE_DOUT) return ST_MAN_MODE;
		if (man_size != {12'd0, cfg_size}) return ST_SIZE_MISM;
		if (hdr[2] != TARGET_ANY && hdr[2] != cfg_target) return ST_TARGET;
		if (!flags[2]) return ST_BOARD;
		if (~crc_acc != man_crc) return ST_CRC;
		return ST_OK;
	endfunction

	task automatic take_byte(input logic [7:0] b, input logic lst);
		status_t st;
		verdict_t e;
		if (pos < cfg_size) parse_byte(pos, b);
		if (pos != 20'hFFFFF) pos = pos + 1;
		if (lst) begin
			st = judge_image();
			e = '0;
			e.status = st;
			if (st == ST_OK || st == ST_CRC) e.crc = ~crc_acc;
			if (st == ST_OK || (st >= ST_MAN_MAGIC && st <= ST_CRC)) begin
				e.offset = 20'(16 + irom_len - MAN_BYTES);
				e.target = hdr[2];
			end
			verdict_q.push_back(e);
			clear_image();
		end
	endtask

	task automatic compare_verdict(input logic [63:0] d);
		verdict_t e, a;
		a.status = d[3:0];
		a.crc = d[35:4];
		a.offset = d[55:36];
		a.target = d[63:56];
		if (verdict_q.size() == 0) begin
			$display("%0t: verdict transfer with none expected, actual %h", $realtime, d);
			fail_count++;
		end else begin
			e = verdict_q.pop_front();
			if (a.status != e.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime, e.status, a.status);
				fail_count++;
			end
			if (a.crc != e.crc) begin
				$display("%0t: crc expected %h actual %h", $realtime, e.crc, a.crc);
				fail_count++;
			end
			if (a.offset != e.offset) begin
				$display("%0t: offset expected %h actual %h", $realtime, e.offset, a.offset);
				fail_count++;
			end
			if (a.target != e.target) begin
				$display("%0t: target expected %h actual %h", $realtime, e.target, a.target);
				fail_count++;
			end
		end
	endtask

	initial begin
		fail_count = 0;
		verdicts_seen = 0;
		cfg_size = '0;
		cfg_target = '0;
		clear_image();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_size = '0;
			cfg_target = '0;
			clear_image();
			verdict_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				compare_verdict(m_axis_tdata);
				verdicts_seen++;
			end
			if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tlast);
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_IMAGE_SIZE) cfg_size = pwdata[19:0];
				else if (paddr == ADDR_TARGET_ROM) cfg_target = pwdata[7:0];
			end
		end
	end

endmodule

FILE: sim/tb.sv
// tb: stimulus and verdict for the firmware image verifier top level
// builds well-formed and damaged images; depends on fiv_pkg and fiv_checker
`timescale 1ns / 1ps

module tb;
	import fiv_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [63:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, pending, verdicts_seen;
	int bytes_sent = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	logic [7:0] img [$];
	int         img_size, irom_len, stream_len;

	logic [7:0] board_id [20] = '{8'h47, 8'h4B, 8'h30, 8'h31, 8'h5F, 8'h49, 8'h52, 8'h5F,
		8'h4D, 8'h49, 8'h4E, 8'h49, 8'h5F, 8'h56, 8'h31, 8'h30, 8'h35, 8'h00, 8'h00, 8'h00};
	logic [7:0] magic_id [8] = '{8'h49, 8'h52, 8'h41, 8'h43, 8'h4F, 8'h54, 8'h41, 8'h31};

	firmware_image_verifier_top DUT (.*);

	fiv_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("firmware_image_verifier_top: mismatch");
		$finish;
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
				m_axis_tready = 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				m_axis_tready = 1'b1;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] sz, input logic [7:0] tg);
		wait_idle();
		apb_write(ADDR_IMAGE_SIZE, sz);
		apb_write(ADDR_TARGET_ROM, {24'd0, tg});
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tlast = lst;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_len; i++)
			send_byte(i < img.size() ? img[i] : 8'($urandom), i == stream_len - 1);
		s_axis_tvalid = 1'b0;
		s_axis_tlast = 1'b0;
	endtask

	function automatic logic [31:0] image_crc();
		logic [31:0] c;
		int m;
		c = 32'hFFFFFFFF;
		m = 16 + irom_len - 64;
		for (int i = 0; i < img_size; i++) begin
			c = c ^ {24'd0, (irom_len >= 64 && i >= m + 16 && i < m + 20) ? 8'h00 : img[i]};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		end
		return ~c;
	endfunction

	// lay out boot header, irom with manifest at its end, ram header, filler
	task automatic build_image(input logic [7:0] man_target);
		logic [31:0] ent, c;
		int m, r;
		ent = $urandom;
		img.delete();
		for (int i = 0; i < img_size; i++) img.push_back(8'($urandom));
		img[0] = BOOT_MAGIC0;
		img[1] = BOOT_MAGIC1;
		img[2] = MODE_DOUT;
		for (int i = 0; i < 4; i++) begin
			img[4 + i] = ent[8*i +: 8];
			img[8 + i] = 8'h00;
			img[12 + i] = 8'(irom_len >> (8 * i));
		end
		r = 16 + irom_len;
		if (irom_len >= 64) begin
			m = r - 64;
			for (int i = 0; i < 8; i++) img[m + i] = magic_id[i];
			img[m + 8] = MAN_VER;
			img[m + 9] = MAN_VER;
			img[m + 10] = man_target;
			img[m + 11] = MODE_DOUT;
			for (int i = 0; i < 4; i++) img[m + 12 + i] = 8'(img_size >> (8 * i));
			for (int i = 0; i < 20; i++) img[m + 20 + i] = board_id[i];
		end
		if (r < img_size) img[r] = RAM_MAGIC;
		if (r + 2 < img_size) img[r + 2] = MODE_DOUT;
		for (int i = 0; i < 4; i++)
			if (r + 4 + i < img_size) img[r + 4 + i] = ent[8*i +: 8];
		if (irom_len >= 64) begin
			c = image_crc();
			for (int i = 0; i < 4; i++) img[m + 16 + i] = c[8*i +: 8];
		end
	endtask

	// one image aimed at one outcome; fault codes follow the status list
	task automatic run_image(input status_t fault);
		logic [7:0] tg, mt;
		logic [31:0] sz;
		int m, r;
		case ($urandom_range(0, 3))
			0: tg = 8'h00;
			1: tg = 8'hFF;
			default: tg = 8'($urandom);
		endcase
		irom_len = (fault == ST_NO_MANIFEST) ? $urandom_range(1, 63) : $urandom_range(64, 110);
		img_size = 16 + irom_len + 8 + $urandom_range(0, 12);
		if (fault == ST_NO_RAM_HDR) img_size = 16 + irom_len + $urandom_range(0, 7);
		mt = $urandom_range(0, 1) ? tg : 8'hFF;
		if (fault == ST_TARGET) mt = (tg ^ 8'h01) == 8'hFF ? tg ^ 8'h02 : tg ^ 8'h01;
		build_image(mt);
		r = 16 + irom_len;
		m = r - 64;
		sz = img_size;
		stream_len = img_size;
		if ($urandom_range(0, 4) == 0) stream_len += $urandom_range(1, 6);
		case (fault)
			ST_SIZE: begin
				case ($urandom_range(0, 3))
					0: sz = 0;
					1: sz = 15;
					2: sz = 32'hFE001;
					default: sz = 32'hFFFFF;
				endcase
			end
			ST_MAGIC:      img[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
			ST_MODE:       img[2] ^= 8'(1 << $urandom_range(0, 7));
			ST_IROM: begin
				if ($urandom_range(0, 1)) img[8 + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
				else img[15] = 8'($urandom_range(1, 255));
			end
			ST_RAM_HDR:    img[r + 2 * $urandom_range(0, 1) + ($urandom_range(0, 1) ? 5 : 0)] ^= 8'h10;
			ST_MAN_MAGIC:  img[m + $urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
			ST_VERSION:    img[m + 8 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
			ST_MAN_MODE:   img[m + 11] ^= 8'(1 << $urandom_range(0, 7));
			ST_SIZE_MISM:  img[m + 12 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
			ST_BOARD:      img[m + 20 + $urandom_range(0, 19)] ^= 8'(1 << $urandom_range(0, 7));
			ST_CRC:        img[$urandom_range(16, img_size - 1)] ^= 8'(1 << $urandom_range(0, 7));
			ST_TRUNCATED:  stream_len = $urandom_range(1, img_size - 1);
			default: ;
		endcase
		set_regs(sz, tg);
		send_stream();
	endtask

	// short streams of random bytes under random register values
	task automatic run_noise();
		logic [31:0] sz;
		sz = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 20'hFFFFF);
		set_regs(sz, 8'($urandom));
		img.delete();
		stream_len = $urandom_range(1, 30);
		send_stream();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: single byte streams at the data extremes, a three byte stream, then every outcome once
		set_regs(0, 8'h00);
		img = '{8'h00};
		stream_len = 1;
		send_stream();
		img = '{8'hFF};
		send_stream();
		set_regs(32'hFE000, 8'hFF);
		img = '{8'hEA, 8'h04, 8'h03};
		stream_len = 3;
		send_stream();
		for (int f = 0; f < 16; f++) run_image(status_t'(f));

		// long receiver hold-off while single byte verdicts pile up
		set_regs(16, 8'h00);
		hold_req = 1'b1;
		img.delete();
		stream_len = 1;
		repeat (40) send_stream();

		while (bytes_sent < 1500 || verdicts_seen < 60) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: run_image(ST_OK);
				4, 5:       run_noise();
				default:    run_image(status_t'($urandom_range(1, 15)));
			endcase
		end

		// closing stretch with no idling on either side
		idle_on = 1'b0;
		do run_image(ST_OK); while (bytes_sent < 1750);

		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("firmware_image_verifier_top: match");
		else
			$display("firmware_image_verifier_top: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
src/fiv_pkg.sv
src/fiv_front.sv
src/fiv_fifo.sv
src/fiv_back.sv
src/firmware_image_verifier_top.sv
sim/fiv_checker.sv
sim/tb.sv
